@@ rtl/nk_landscape_fitness_core_macros.svh @@
// -----------------------------------------------------------------------------
// NK landscape fitness core assertion macros
// Shared property forms for the checkers of the fitness core.
// -----------------------------------------------------------------------------
`ifndef NK_LANDSCAPE_FITNESS_CORE_MACROS_SVH
`define NK_LANDSCAPE_FITNESS_CORE_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define NKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nkf check failed: next-cycle property");

// The consequent must hold in the same clock as the antecedent.
`define NKF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nkf check failed: same-cycle property");

`endif

@@ rtl/nkf_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// NK landscape fitness package
// Field widths, word layout, register indexes and the controller interface.
// -----------------------------------------------------------------------------
package nkf_pkg;

  // Field widths.
  localparam int SYM_W   = 2;
  localparam int BLOCK_W = 6;
  localparam int ENTRY_W = 6;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 22;
  localparam int BS_W    = 2;
  localparam int AS_W    = 3;

  // Table store geometry.
  localparam int STORE_BLOCKS  = 64;
  localparam int STORE_ENTRIES = 64;
  localparam int ADDR_W        = BLOCK_W + ENTRY_W;

  // Input word layout, lowest bit first.
  localparam int SYM_LSB    = 0;
  localparam int BLOCK_LSB  = SYM_LSB + SYM_W;
  localparam int ENTRY_LSB  = BLOCK_LSB + BLOCK_W;
  localparam int VALUE_LSB  = ENTRY_LSB + ENTRY_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET   = 1'b1;
  localparam logic [BS_W-1:0] BS_RESET = 2'd3;
  localparam logic [AS_W-1:0] AS_RESET = 3'd2;

  // Limits.
  localparam int MAX_LENGTH_DEF = 64;
  localparam int MAX_WINDOW_DEF = 3;
  localparam int MAX_ALPHABET   = 4;

  // Request kinds carried in tuser.
  localparam logic REQ_TABLE  = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;      // write a table entry
    logic start;   // take a symbol and issue the table read
    logic finish;  // accumulate and, on the last symbol, emit
  } nkf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pend_last;  // the symbol in flight closes the genotype
    logic out_free;   // the output register can take a word this cycle
  } nkf_stat_t;

endpackage

@@ rtl/nk_landscape_fitness_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// NK landscape fitness core
// Scores a streamed genotype against per-block fitness tables held on chip.
// -----------------------------------------------------------------------------
// A table word (tuser low) writes one 16-bit entry of the 64 x 64 table store.
// For a symbol word (tuser high) the window index is formed and the
// single-port table memory is read first, and the registered entry is then
// added to the running sum in the accumulate state. A symbol
// with tlast set also loads the total into the output register; if a previous
// total is still waiting there, it holds for as long as that word is not
// taken. The table store has no reset; every entry a genotype reaches must
// have been written first. No clearing pass follows reset.
module nk_landscape_fitness_core #(
  parameter int MAX_LENGTH = nkf_pkg::MAX_LENGTH_DEF,
  parameter int MAX_WINDOW = nkf_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input words.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // symbol[1:0], table_block[7:2], table_entry[13:8], table_value[29:14]
  input  logic [nkf_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type[0]
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  // Output words.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fitness_sum[21:0]
  output logic [nkf_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nkf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nkf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nkf_pkg::*;

  nkf_cmd_t         cmd;
  nkf_stat_t        stat;
  logic [SUM_W-1:0] out_sum;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Controller.
  nkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  nkf_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_symbol (s_tdata[SYM_LSB +: SYM_W]),
    .in_last   (s_tlast),
    .in_block  (s_tdata[BLOCK_LSB +: BLOCK_W]),
    .in_entry  (s_tdata[ENTRY_LSB +: ENTRY_W]),
    .in_value  (s_tdata[VALUE_LSB +: VALUE_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sum   (out_sum)
  );

  // The total sits in the low bits, zero-filled to whole bytes.
  assign m_tdata = {{(OUT_DATA_W - SUM_W){1'b0}}, out_sum};

endmodule

@@ rtl/nkf_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// NK landscape fitness controller
// Sequences table writes and the two-step read and accumulate of a symbol.
// -----------------------------------------------------------------------------
module nkf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  nkf_pkg::nkf_stat_t stat,
  output nkf_pkg::nkf_cmd_t  cmd
);
  import nkf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ACC  = 2'b10
  } state_t;

  state_t state, state_next;

  // Input words are taken only while no symbol is in flight.
  assign s_tready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_SYMBOL) begin
            cmd.start  = 1'b1;
            state_next = S_ACC;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_ACC: begin
        // A closing symbol waits until the output register is free.
        if (!stat.pend_last || stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/nkf_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// NK landscape fitness datapath
// Table memory, symbol window, window index, running sum and output register.
// -----------------------------------------------------------------------------
module nkf_dp #(
  parameter int MAX_LENGTH = nkf_pkg::MAX_LENGTH_DEF,
  parameter int MAX_WINDOW = nkf_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nkf_pkg::nkf_cmd_t                 cmd,
  output nkf_pkg::nkf_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [nkf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nkf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [nkf_pkg::SYM_W-1:0]         in_symbol,
  input  logic                              in_last,
  input  logic [nkf_pkg::BLOCK_W-1:0]       in_block,
  input  logic [nkf_pkg::ENTRY_W-1:0]       in_entry,
  input  logic [nkf_pkg::VALUE_W-1:0]       in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nkf_pkg::SUM_W-1:0]         out_sum
);
  import nkf_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [BS_W-1:0] block_size;
  logic [AS_W-1:0] alphabet_size;

  // Stream state.
  logic [SYM_W-1:0] win [MAX_WINDOW];
  logic [POS_W-1:0] pos;
  logic [SUM_W-1:0] sum;
  logic             add_en;
  logic             pend_last;

  // Table memory and its registered read word.
  logic [VALUE_W-1:0] mem [STORE_BLOCKS * STORE_ENTRIES];
  logic [VALUE_W-1:0] rdata;

  // Combinational terms.
  logic [WIN_W-1:0]   bs_eff;
  logic [AS_W-1:0]    base;
  logic [SYM_W-1:0]   win_shift [MAX_WINDOW];
  logic               in_range;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   blk_off;
  logic [ENTRY_W-1:0] idx;
  logic               acc_hit;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SUM_W-1:0]   sum_new;

  // Out-of-range register values are clamped to the supported span.
  always_comb begin
    if (block_size == '0) begin
      bs_eff = WIN_W'(1);
    end else if (int'(block_size) > MAX_WINDOW) begin
      bs_eff = WIN_W'(MAX_WINDOW);
    end else begin
      bs_eff = WIN_W'(block_size);
    end
    if (alphabet_size < AS_W'(2)) begin
      base = AS_W'(2);
    end else if (int'(alphabet_size) > MAX_ALPHABET) begin
      base = AS_W'(MAX_ALPHABET);
    end else begin
      base = alphabet_size;
    end
  end

  // The window after the new symbol is shifted in at the young end.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      win_shift[i] = win[i+1];
    end
    win_shift[MAX_WINDOW-1] = in_symbol;
  end

  // Window index, first symbol most significant, kept modulo the table size.
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (i >= MAX_WINDOW - int'(bs_eff)) begin
        idx = ENTRY_W'(idx * base + ENTRY_W'(win_shift[i]));
      end
    end
  end

  // Block number of the window that this symbol closes.
  assign in_range = (int'(pos) < MAX_LENGTH);
  assign pos_inc  = pos + POS_W'(1);
  assign blk_off  = pos_inc - POS_W'(bs_eff);
  assign acc_hit  = in_range && (int'(pos_inc) >= int'(bs_eff)) &&
                    (int'(blk_off) < STORE_BLOCKS);
  assign rd_addr  = {BLOCK_W'(blk_off), idx};
  assign sum_new  = sum + (add_en ? SUM_W'(rdata) : SUM_W'(0));

  // Table memory: one write or one read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{in_block, in_entry}] <= in_value;
    end
    if (cmd.start && acc_hit) begin
      rdata <= mem[rd_addr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BS_RESET;
      alphabet_size <= AS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: block_size    <= cfg_data[BS_W-1:0];
        REG_ALPHABET:   alphabet_size <= cfg_data[AS_W-1:0];
        default: ;
      endcase
    end
  end

  // Window, position and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '{default: '0};
      pos       <= '0;
      sum       <= '0;
      add_en    <= 1'b0;
      pend_last <= 1'b0;
    end else if (cmd.start) begin
      // Symbols past the maximum length leave the window and position alone.
      if (in_range) begin
        win <= win_shift;
        pos <= pos_inc;
      end
      add_en    <= acc_hit;
      pend_last <= in_last;
    end else if (cmd.finish) begin
      if (pend_last) begin
        win <= '{default: '0};
        pos <= '0;
        sum <= '0;
      end else begin
        sum <= sum_new;
      end
    end
  end

  // Output register for the genotype total.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && pend_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && pend_last) begin
      out_sum <= sum_new;
    end
  end

  assign stat.pend_last = pend_last;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

@@ rtl/nkf_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// NK landscape fitness port checker
// Watches the ports of the fitness core for handshake and sequencing slips.
// -----------------------------------------------------------------------------
`include "nk_landscape_fitness_core_macros.svh"

module nkf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [nkf_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import nkf_pkg::*;

  // A stalled output word holds.
  `NKF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The fill bits above the total are zero.
  `NKF_ASSERT_NOW(a_out_fill, m_tvalid, m_tdata[OUT_DATA_W-1:SUM_W] == '0)

  // A symbol occupies the core while it is accumulated.
  `NKF_ASSERT_NEXT(a_sym_busy, s_tvalid && s_tready && s_tuser == REQ_SYMBOL, !s_tready)

  // A table write leaves the core ready for the next word.
  `NKF_ASSERT_NEXT(a_tbl_ready, s_tvalid && s_tready && s_tuser == REQ_TABLE, s_tready)

endmodule

bind nk_landscape_fitness_core nkf_checker u_nkf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
